FILE: hdl/lpt_pkg.sv
// Shared constants, field layout and controller/datapath interface types.
`timescale 1ns / 1ps

package lpt_pkg;

  // Default sizing of the table.
  localparam int unsigned DEF_TABLE_DEPTH = 65536;
  localparam int unsigned DEF_KEY_BITS    = 14;

  // Stride register.
  localparam int unsigned STRIDE_W     = 8;
  localparam logic [7:0]  STRIDE_RESET = 8'd200;

  // Action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Result status codes.
  localparam int unsigned      STATUS_W     = 2;
  localparam logic [1:0]       STATUS_OK    = 2'd0;
  localparam logic [1:0]       STATUS_MISS  = 2'd1;
  localparam logic [1:0]       STATUS_RANGE = 2'd2;

  // Result beat layout: found, location, status from bit 0 up.
  localparam int unsigned LOC_W       = 16;
  localparam int unsigned OUT_FIELD_W = 1 + LOC_W + STATUS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr;         // clear one table entry, advance clear pointer
    logic       load;        // capture the accepted input beat
    logic       mul;         // register key * stride
    logic       home;        // load probe pointer with the home slot
    logic       rd;          // read the entry at the probe pointer
    logic       wr;          // store the key at the probe pointer
    logic       inc;         // advance the probe pointer
    logic       res_set;     // capture a result
    logic       res_found;
    logic [1:0] res_status;
    logic       out_load;    // move the result into the output register
  } lpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // clear pointer is at the last entry
    logic home_oor;   // home slot lies beyond the table
    logic is_lookup;  // current item is a lookup
    logic rd_valid;   // entry read holds a key
    logic rd_match;   // entry read holds the current key
    logic slot_last;  // probe pointer is at the last entry
  } lpt_stat_t;

endpackage

FILE: hdl/lpt_datapath.sv
// Datapath: stride register, multiplier, probe pointer, key table and result registers.
`timescale 1ns / 1ps

module lpt_datapath import lpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = DEF_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [STRIDE_W-1:0] cfg_wdata_i,
  input  logic                in_action_i,
  input  logic [KEY_BITS-1:0] in_key_i,
  input  lpt_cmd_t            cmd_i,
  output lpt_stat_t           stat_o,
  output logic                out_found_o,
  output logic [LOC_W-1:0]    out_loc_o,
  output logic [STATUS_W-1:0] out_status_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned PROD_W = KEY_BITS + STRIDE_W;
  localparam int unsigned CMP_W  = (PROD_W > IDX_W + 1) ? PROD_W : IDX_W + 1;
  localparam int unsigned ENT_W  = KEY_BITS + 1;

  logic [STRIDE_W-1:0] stride_q;
  logic                act_q;
  logic [KEY_BITS-1:0] key_q;
  logic [PROD_W-1:0]   prod_q;
  logic [IDX_W-1:0]    slot_q;
  logic [IDX_W-1:0]    clr_q;
  logic [ENT_W-1:0]    rd_q;
  logic                res_found_q;
  logic [LOC_W-1:0]    res_loc_q;
  logic [STATUS_W-1:0] res_status_q;
  logic                out_found_q;
  logic [LOC_W-1:0]    out_loc_q;
  logic [STATUS_W-1:0] out_status_q;

  // Top bit of each entry is its valid flag, the rest is the stored key.
  logic [ENT_W-1:0]    mem [TABLE_DEPTH];
  logic [IDX_W-1:0]    waddr;
  logic [ENT_W-1:0]    wdata;
  logic                we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RESET;
      clr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        stride_q <= cfg_wdata_i;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_action_i;
      key_q <= in_key_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(key_q) * PROD_W'(stride_q);
    end
    if (cmd_i.home) begin
      slot_q <= IDX_W'(prod_q);
    end else if (cmd_i.inc) begin
      slot_q <= slot_q + IDX_W'(1);
    end
    if (cmd_i.res_set) begin
      res_found_q  <= cmd_i.res_found;
      res_loc_q    <= cmd_i.res_found ? LOC_W'(slot_q) : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_found_q  <= res_found_q;
      out_loc_q    <= res_loc_q;
      out_status_q <= res_status_q;
    end
  end

  assign we    = cmd_i.clr | cmd_i.wr;
  assign waddr = cmd_i.clr ? clr_q : slot_q;
  assign wdata = cmd_i.clr ? '0 : {1'b1, key_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[slot_q];
    end
  end

  assign stat_o.clr_last  = (clr_q == IDX_W'(TABLE_DEPTH - 1));
  assign stat_o.home_oor  = (CMP_W'(prod_q) >= CMP_W'(TABLE_DEPTH));
  assign stat_o.is_lookup = (act_q == ACT_LOOKUP);
  assign stat_o.rd_valid  = rd_q[KEY_BITS];
  assign stat_o.rd_match  = (rd_q[KEY_BITS-1:0] == key_q);
  assign stat_o.slot_last = (slot_q == IDX_W'(TABLE_DEPTH - 1));

  assign out_found_o  = out_found_q;
  assign out_loc_o    = out_loc_q;
  assign out_status_o = out_status_q;

endmodule

FILE: hdl/lpt_ctrl.sv
// Controller state machine: clearing pass, probe sequencing and output handshake.
`timescale 1ns / 1ps

module lpt_ctrl import lpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lpt_stat_t stat_i,
  output lpt_cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_HOME  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_EVAL  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_HOME;
      end
      ST_HOME: begin
        if (stat_i.home_oor) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = STATUS_RANGE;
          state_d          = ST_EMIT;
        end else begin
          cmd_o.home = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stat_i.rd_valid) begin
          // Free slot: an insert stores here, a lookup ends as a miss.
          cmd_o.res_set = 1'b1;
          state_d       = ST_EMIT;
          if (stat_i.is_lookup) begin
            cmd_o.res_status = STATUS_MISS;
          end else begin
            cmd_o.wr         = 1'b1;
            cmd_o.res_found  = 1'b1;
            cmd_o.res_status = STATUS_OK;
          end
        end else if (stat_i.is_lookup && stat_i.rd_match) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_found  = 1'b1;
          cmd_o.res_status = STATUS_OK;
          state_d          = ST_EMIT;
        end else if (stat_i.slot_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = stat_i.is_lookup ? STATUS_MISS : STATUS_RANGE;
          state_d          = ST_EMIT;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/linear_probe_table_insert_lookup.sv
// Top level of the linear-probing key table with insert and lookup.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one operation per beat: bit 0 of s_axis_tdata is the
// action (0 insert, 1 lookup) and the bits above it hold the key. Every beat
// produces exactly one result beat on the output stream, in order, holding the
// found flag, the 16-bit slot location and a 2-bit status (ok, miss, range/full).
// The home slot of a key is key times the stride register, which resets to 200.
// The user must write it through cfg_we_i/cfg_wdata_i only while the block is
// idle; the block itself does not enforce this. One operation is processed at
// a time: an item is accepted, its key is multiplied by the stride into a
// register, its home slot is range-checked, then each probed slot takes a
// registered table read followed by a compare, and the result is loaded into
// the output register. A home slot beyond the table skips the table probe.
// After reset the block runs a clearing pass over all TABLE_DEPTH entries, one
// entry per cycle, during which s_axis_tready stays low. A result held by a
// stalled receiver sits in the output register; the next item is accepted and
// probed meanwhile and waits only at the hand-off into that register.

module linear_probe_table_insert_lookup import lpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = DEF_KEY_BITS,
  localparam int unsigned IN_TDATA_W = ((KEY_BITS + 1 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [STRIDE_W-1:0]    cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // action, key
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // found, location, status
);

  lpt_cmd_t            cmd;
  lpt_stat_t           stat;
  logic                out_found;
  logic [LOC_W-1:0]    out_loc;
  logic [STATUS_W-1:0] out_status;

  // The controller sequences the clearing pass and each probe run.
  lpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath owns the table memory and all payload registers.
  lpt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_action_i  (s_axis_tdata[0]),
    .in_key_i     (s_axis_tdata[KEY_BITS:1]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_found_o  (out_found),
    .out_loc_o    (out_loc),
    .out_status_o (out_status)
  );

  // Result beat packed from bit 0 up, padded with zeros to whole bytes.
  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_status, out_loc, out_found};

endmodule

FILE: hdl/lpt_checker.sv
// Port-level checker for the key table, bound to the top level.
`timescale 1ns / 1ps

module lpt_checker import lpt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                found;
  logic [LOC_W-1:0]    loc;
  logic [STATUS_W-1:0] status;

  assign found  = m_axis_tdata[0];
  assign loc    = m_axis_tdata[LOC_W:1];
  assign status = m_axis_tdata[LOC_W+STATUS_W:LOC_W+1];

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Only one operation is in flight: an accepted beat closes the input.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an operation is in progress");

  // The found flag and an ok status always go together.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (found == (status == STATUS_OK)))
    else $error("found flag disagrees with status");

  // A result without a hit reports location zero and a defined failure code.
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !found |-> (loc == '0) &&
      ((status == STATUS_MISS) || (status == STATUS_RANGE)))
    else $error("malformed miss result");

endmodule

bind linear_probe_table_insert_lookup lpt_checker u_lpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/linear_probe_table_insert_lookup_test.sv
// Self-checking testbench for the linear-probing key table with insert and lookup.
`timescale 1ns / 1ps

module linear_probe_table_insert_lookup_test;
  import lpt_pkg::*;

  localparam int unsigned DEPTH   = DEF_TABLE_DEPTH;
  localparam int unsigned KEY_W   = DEF_KEY_BITS;
  localparam int unsigned KEY_MAX = (1 << KEY_W) - 1;
  localparam int unsigned IN_W    = ((KEY_W + 1 + 7) / 8) * 8;
  localparam int unsigned POOL_N  = 16;

  // One operation as it travels on the input stream.
  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } table_op_t;

  // One result as it travels on the output stream.
  typedef struct packed {
    logic             found;
    logic [LOC_W-1:0] location;
    logic [1:0]       status;
  } probe_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [STRIDE_W-1:0]    cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;         // action, key
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;              // found, location, status

  linear_probe_table_insert_lookup DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's table and stride register. The key store is only
  // read behind a set occupancy bit, so its unwritten contents never matter.
  bit               slot_used [DEPTH];
  logic [KEY_W-1:0] slot_key  [DEPTH];
  int unsigned      stride_now = 32'(STRIDE_RESET);

  table_op_t     op_backlog[$];       // operations still to be sent
  probe_result_t pending_results[$];  // results owed by the block, oldest first
  int unsigned   mismatch_count = 0;
  bit            idle_en = 1'b1;      // random gaps and stalls allowed
  int unsigned   send_gap = 0;
  int unsigned   stall_left = 0;

  // Carries out one operation on the shadow table and returns the result the
  // block must give for it. The home slot is key times stride; a home slot past
  // the table end is rejected before the table is touched.
  function automatic probe_result_t probe_table(input logic action,
                                                input logic [KEY_W-1:0] key);
    int unsigned   slot;
    probe_result_t res;
    res = '{found: 1'b0, location: '0, status: STATUS_RANGE};
    slot = key * stride_now;
    if (slot >= DEPTH) return res;
    if (action == ACT_INSERT) begin
      // Walk up to the first free slot; running off the end means full.
      while (slot < DEPTH && slot_used[slot]) slot++;
      if (slot >= DEPTH) return res;
      slot_used[slot] = 1'b1;
      slot_key[slot] = key;
      res = '{found: 1'b1, location: slot[LOC_W-1:0], status: STATUS_OK};
      return res;
    end
    // Lookups stop at a match, at the first free slot, or at the table end.
    while (slot < DEPTH && slot_used[slot]) begin
      if (slot_key[slot] == key) begin
        res = '{found: 1'b1, location: slot[LOC_W-1:0], status: STATUS_OK};
        return res;
      end
      slot++;
    end
    res.status = STATUS_MISS;
    return res;
  endfunction

  // Input side. Every accepted beat is run through the shadow table at once, so
  // the expected results line up with the order in which the block takes items.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      pending_results.push_back(probe_table(s_axis_tdata[0], s_axis_tdata[KEY_W:1]));
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        table_op_t op;
        op = op_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'({op.key, op.action});
        if (idle_en && $urandom_range(0, 99) < 20) send_gap = $urandom_range(1, 8);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: compare each result beat with the oldest expectation, and
  // throttle tready in random bursts.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      probe_result_t got;
      probe_result_t want;
      got.found = m_axis_tdata[0];
      got.location = m_axis_tdata[LOC_W:1];
      got.status = m_axis_tdata[LOC_W+STATUS_W:LOC_W+1];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with nothing expected: found %0d location %0d status %0d",
                   $realtime, got.found, got.location, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.location !== want.location ||
            got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected found %0d location %0d status %0d, got %0d %0d %0d",
                     $realtime, want.found, want.location, want.status,
                     got.found, got.location, got.status);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < 20) begin
      stall_left = $urandom_range(1, 8) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_op(input logic action, input int unsigned key);
    table_op_t op;
    op.action = action;
    op.key = key[KEY_W-1:0];
    op_backlog.push_back(op);
  endtask

  // Waits until every queued operation has been sent and every result returned.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_backlog.size() > 0 || s_axis_tvalid || pending_results.size() > 0);
  endtask

  // Stride writes only happen with the block idle: one result per item means
  // it is done once the last result has left.
  task automatic write_stride(input int unsigned value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[STRIDE_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stride_now = value;
  endtask

  // Random traffic for one stride setting. Most operations draw from a small
  // key pool whose home slots fall inside the table, so inserts pile up into
  // probe chains and lookups hit, miss behind occupied slots or walk those
  // chains. The pool is sometimes a run of adjacent keys, which makes the
  // chains of neighboring home slots merge. A tenth of the operations use any
  // key at all, which for larger strides mostly lands beyond the table.
  task automatic queue_random_ops(input int unsigned count);
    logic [KEY_W-1:0] pool [POOL_N];
    int unsigned      top;
    int unsigned      base;
    bit               adjacent;
    top = (stride_now == 0) ? KEY_MAX : (DEPTH - 1) / stride_now;
    if (top > KEY_MAX) top = KEY_MAX;
    adjacent = 1'($urandom_range(0, 1));
    base = $urandom_range(0, (top > POOL_N) ? top - POOL_N : 0);
    foreach (pool[i])
      pool[i] = adjacent ? KEY_W'((base + i > top) ? top : base + i)
                         : KEY_W'($urandom_range(0, top));
    repeat (count) begin
      if ($urandom_range(0, 99) < 10)
        push_op(1'($urandom_range(0, 1)), $urandom_range(0, KEY_MAX));
      else
        push_op(($urandom_range(0, 99) < 45) ? ACT_INSERT : ACT_LOOKUP,
                pool[$urandom_range(0, POOL_N - 1)]);
    end
  endtask

  initial begin
    int unsigned strides [8];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset stride of 200: empty-table miss, key 0 as an ordinary key, a
    // duplicate insert, the largest key and the edge of the home-slot range.
    push_op(ACT_LOOKUP, 0);
    push_op(ACT_INSERT, 0);
    push_op(ACT_LOOKUP, 0);
    push_op(ACT_INSERT, 0);
    push_op(ACT_LOOKUP, 0);
    push_op(ACT_INSERT, KEY_MAX);
    push_op(ACT_LOOKUP, KEY_MAX);
    push_op(ACT_INSERT, 327);
    push_op(ACT_INSERT, 328);
    push_op(ACT_LOOKUP, 1);
    push_op(ACT_INSERT, 1);
    push_op(ACT_LOOKUP, 1);
    push_op(ACT_LOOKUP, 'h2AAA);
    push_op(ACT_INSERT, 'h1555);

    // Largest stride: key 257 lands on the very last slot, so a second insert
    // finds the table full above its home slot.
    write_stride(255);
    push_op(ACT_INSERT, 257);
    push_op(ACT_INSERT, 257);
    push_op(ACT_LOOKUP, 257);

    // Key 771 also homes on the last slot, which holds another key: the
    // lookup runs off the table end and the insert finds no room.
    write_stride(85);
    push_op(ACT_LOOKUP, 771);
    push_op(ACT_INSERT, 771);

    // Smallest nonzero stride, then zero, where every key homes on slot 0 and
    // has to walk past the entries already stored there.
    write_stride(1);
    push_op(ACT_INSERT, KEY_MAX);
    push_op(ACT_LOOKUP, KEY_MAX);
    write_stride(0);
    push_op(ACT_INSERT, 5);
    push_op(ACT_LOOKUP, 5);
    push_op(ACT_LOOKUP, 9);

    // Random phases over several strides, the reset value rewritten among them.
    // The stride-zero phase is short since all of its keys share one chain.
    strides = '{200, 1, 255, 0, 17, 0, 0, 0};
    for (int p = 5; p < 8; p++) strides[p] = $urandom_range(2, 254);
    foreach (strides[p]) begin
      write_stride(strides[p]);
      idle_en = (p != 7);
      queue_random_ops((strides[p] == 0) ? 30 : 200);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Covers the clearing pass after reset and the longest probe chains with room
  // to spare; reaching it means results went missing or the block hung.
  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/lpt_pkg.sv
hdl/lpt_datapath.sv
hdl/lpt_ctrl.sv
hdl/linear_probe_table_insert_lookup.sv
hdl/lpt_checker.sv
verif/linear_probe_table_insert_lookup_test.sv
